>>> rtl/cltok_pkg.sv
package cltok_pkg;

  localparam int unsigned TOKEN_LIMIT_DEF = 100;
  localparam int unsigned LINE_LENGTH_DEF = 1024;

  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_END     = 1'b1;
  localparam logic RESULT_TOKEN = 1'b0;
  localparam logic RESULT_SUM   = 1'b1;

  typedef enum logic [3:0] {
    MODE_BETWEEN = 4'b0001,
    MODE_PLAIN   = 4'b0010,
    MODE_QUOTED  = 4'b0100,
    MODE_DONE    = 4'b1000
  } mode_e;

  typedef struct packed {
    logic       result_kind;
    logic [6:0] token_index;
    logic [9:0] token_start;
    logic [9:0] token_length;
    logic [6:0] token_count;
    logic [6:0] command_count;
    logic       background;
    logic       output_redirect;
    logic       input_redirect;
    logic       line_empty;
    logic       last;
  } result_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  endfunction

  // Returns (s - n) mod 3 for s in 0..2 and n in 1..3.
  function automatic logic [1:0] slot_back(input logic [1:0] s, input logic [1:0] n);
    logic [2:0] t;
    t = {1'b0, s} + 3'd3 - {1'b0, n};
    if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

endpackage

>>> rtl/command_line_tokenizer_unit.sv
// Command line tokenizer.
// The input channel (valid_i, stall_o, kind_i, char_code_i) takes one byte of a
// shell command line per transaction, then an end of line transaction (kind_i
// high). The output channel (valid_o, stall_i and the result fields) carries a
// token report for each finished token and one summary per line, marked by
// last_o.
// Each input transaction is processed in the cycle it is accepted, and its
// results are registered in the result queue. The block takes one byte per
// cycle while stall_o is low; the scan state is updated as each byte is taken.
// An end of line transaction with a token still open yields two results,
// which leave the four-entry result queue one after the other.
// When the receiver stalls, results wait in the queue; stall_o rises while
// the queue holds three or more results, so that room for two is left on accept.
// Reset empties the queue and returns the scanner to the start of a line
// with no tokens found.
module command_line_tokenizer_unit #(
  parameter int unsigned TOKEN_LIMIT = cltok_pkg::TOKEN_LIMIT_DEF,
  parameter int unsigned LINE_LENGTH = cltok_pkg::LINE_LENGTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic       kind_i,
  input  logic [7:0] char_code_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic       result_kind_o,
  output logic [6:0] token_index_o,
  output logic [9:0] token_start_o,
  output logic [9:0] token_length_o,
  output logic [6:0] token_count_o,
  output logic [6:0] command_count_o,
  output logic       background_o,
  output logic       output_redirect_o,
  output logic       input_redirect_o,
  output logic       line_empty_o,
  output logic       last_o
);
  import cltok_pkg::*;

  localparam int unsigned PosW  = $clog2(LINE_LENGTH);
  localparam int unsigned CntW  = $clog2(TOKEN_LIMIT + 1);
  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = 2;
  localparam int unsigned FillW = 3;

  mode_e            mode_q, mode_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             prev_q, prev_d;
  logic [PosW-1:0]  start_q, start_d;
  logic [CntW-1:0]  tokens_q, tokens_d;
  logic             saw_q, saw_d;
  logic [9:0]       info_q [3];
  logic [9:0]       info_d [3];
  logic [1:0]       slot_q, slot_d;
  logic [7:0]       first_q, first_d;

  logic             in_acc, out_acc;
  logic             byte_sp, cut, in_tok, finish;
  logic [PosW-1:0]  tok_len;
  logic [9:0]       new_info;
  logic [9:0]       fin_info [3];
  logic [CntW-1:0]  fin_tokens;
  logic [1:0]       fin_slot;

  logic             bg, outr, inr;
  logic [CntW-1:0]  cnt1, cnt2, cnt3;
  logic [9:0]       t_bg, t_out, t_in;

  logic [CntW+6:0]  ext_index, ext_count, ext_cmd;
  logic [PosW+9:0]  ext_start, ext_len;

  result_t          rep, sum, entry0;
  result_t          fifo_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [FillW-1:0] fill_q, fill_d;
  logic             push0, push1;
  result_t          head;

  assign in_acc  = valid_i && !stall_o;
  assign out_acc = valid_o && !stall_i;

  assign byte_sp = is_space(char_code_i);
  assign in_tok  = (mode_q == MODE_PLAIN) || (mode_q == MODE_QUOTED);
  assign cut     = (pos_q >= PosW'(LINE_LENGTH - 1)) || (char_code_i == CHAR_NUL) ||
                   ((char_code_i == CHAR_HASH) && ((pos_q == '0) || prev_q));
  assign tok_len = pos_q - start_q;

  always_comb begin
    new_info = '0;
    if (tok_len != '0) begin
      new_info = {1'b0, 1'b1, first_q};
    end
    if (tok_len == PosW'(1)) begin
      new_info[9] = 1'b1;
    end
  end

  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    prev_d  = prev_q;
    start_d = start_q;
    first_d = first_q;
    saw_d   = saw_q;
    finish  = 1'b0;

    if (kind_i == KIND_END) begin
      finish = in_tok;
    end else if (mode_q != MODE_DONE) begin
      if (cut) begin
        finish = in_tok;
      end else begin
        if (!byte_sp) begin
          saw_d = 1'b1;
        end
        case (mode_q)
          MODE_BETWEEN: begin
            if (!byte_sp) begin
              if (char_code_i == CHAR_QUOTE) begin
                mode_d  = MODE_QUOTED;
                start_d = pos_q + 1'b1;
                first_d = '0;
              end else begin
                mode_d  = MODE_PLAIN;
                start_d = pos_q;
                first_d = char_code_i;
              end
            end
          end
          MODE_PLAIN: begin
            finish = byte_sp;
          end
          MODE_QUOTED: begin
            if (char_code_i == CHAR_QUOTE) begin
              finish = 1'b1;
            end else if (pos_q == start_q) begin
              first_d = char_code_i;
            end
          end
          default: begin
          end
        endcase
        prev_d = byte_sp;
        pos_d  = pos_q + 1'b1;
      end
    end

    fin_info   = info_q;
    fin_tokens = tokens_q;
    fin_slot   = slot_q;
    if (finish) begin
      fin_info[slot_q] = new_info;
      fin_tokens       = tokens_q + 1'b1;
      fin_slot         = (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
      mode_d           = (fin_tokens == CntW'(TOKEN_LIMIT)) ? MODE_DONE : MODE_BETWEEN;
    end
    if ((kind_i == KIND_BYTE) && (mode_q != MODE_DONE) && cut) begin
      mode_d = MODE_DONE;
    end

    tokens_d = fin_tokens;
    slot_d   = fin_slot;
    info_d   = fin_info;

    if (kind_i == KIND_END) begin
      mode_d   = MODE_BETWEEN;
      pos_d    = '0;
      prev_d   = 1'b0;
      start_d  = '0;
      tokens_d = '0;
      saw_d    = 1'b0;
      first_d  = '0;
      slot_d   = '0;
      info_d   = '{default: '0};
    end
  end

  // The trailing tokens are checked from the last one backward.
  always_comb begin
    t_bg  = fin_info[slot_back(fin_slot, 2'd1)];
    bg    = (fin_tokens != '0) && t_bg[9] && (t_bg[7:0] == CHAR_AMP);
    cnt1  = fin_tokens - CntW'(bg);
    t_out = fin_info[slot_back(fin_slot, 2'd1 + {1'b0, bg})];
    outr  = (cnt1 != '0) && t_out[8] && (t_out[7:0] == CHAR_GT);
    cnt2  = cnt1 - CntW'(outr);
    t_in  = fin_info[slot_back(fin_slot, 2'd1 + {1'b0, bg} + {1'b0, outr})];
    inr   = (cnt2 != '0) && t_in[8] && (t_in[7:0] == CHAR_LT);
    cnt3  = cnt2 - CntW'(inr);
  end

  assign ext_index = {7'd0, tokens_q};
  assign ext_count = {7'd0, fin_tokens};
  assign ext_cmd   = {7'd0, cnt3};
  assign ext_start = {10'd0, start_q};
  assign ext_len   = {10'd0, tok_len};

  always_comb begin
    rep              = '0;
    rep.result_kind  = RESULT_TOKEN;
    rep.token_index  = ext_index[6:0];
    rep.token_start  = ext_start[9:0];
    rep.token_length = ext_len[9:0];

    sum                 = '0;
    sum.result_kind     = RESULT_SUM;
    sum.token_count     = ext_count[6:0];
    sum.command_count   = ext_cmd[6:0];
    sum.background      = bg;
    sum.output_redirect = outr;
    sum.input_redirect  = inr;
    sum.line_empty      = !saw_q;
    sum.last            = 1'b1;

    entry0 = finish ? rep : sum;
  end

  assign push0 = in_acc && (finish || (kind_i == KIND_END));
  assign push1 = in_acc && finish && (kind_i == KIND_END);

  always_comb begin
    fill_d = fill_q + FillW'(push0) + FillW'(push1) - FillW'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BETWEEN;
      pos_q    <= '0;
      prev_q   <= 1'b0;
      start_q  <= '0;
      tokens_q <= '0;
      saw_q    <= 1'b0;
      first_q  <= '0;
      slot_q   <= '0;
      info_q   <= '{default: '0};
    end else if (in_acc) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      prev_q   <= prev_d;
      start_q  <= start_d;
      tokens_q <= tokens_d;
      saw_q    <= saw_d;
      first_q  <= first_d;
      slot_q   <= slot_d;
      info_q   <= info_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0) begin
      fifo_q[wr_q] <= entry0;
    end
    if (push1) begin
      fifo_q[wr_q + 1'b1] <= sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_q + PtrW'(push0) + PtrW'(push1);
      rd_q   <= rd_q + PtrW'(out_acc);
      fill_q <= fill_d;
    end
  end

  assign stall_o = fill_q >= FillW'(Depth - 1);
  assign valid_o = fill_q != '0;
  assign head    = fifo_q[rd_q];

  assign result_kind_o     = head.result_kind;
  assign token_index_o     = head.token_index;
  assign token_start_o     = head.token_start;
  assign token_length_o    = head.token_length;
  assign token_count_o     = head.token_count;
  assign command_count_o   = head.command_count;
  assign background_o      = head.background;
  assign output_redirect_o = head.output_redirect;
  assign input_redirect_o  = head.input_redirect;
  assign line_empty_o      = head.line_empty;
  assign last_o            = head.last;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(Depth))
    else $error("result queue overflow");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (kind_i == KIND_END)) |=> valid_o)
    else $error("end of line produced no result");

  a_end_clears_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (kind_i == KIND_END)) |=>
      ((tokens_q == '0) && (mode_q == MODE_BETWEEN) && (pos_q == '0)))
    else $error("line state not cleared after end of line");

  a_token_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tokens_q <= CntW'(TOKEN_LIMIT)) &&
    ((tokens_q != CntW'(TOKEN_LIMIT)) || (mode_q == MODE_DONE)))
    else $error("token count past limit");
`endif

endmodule
